// File: design/pdag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdag_pkg;

  // field widths
  localparam int ERR_W      = 24;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int KF_W       = 13;
  localparam int BANK_W     = 13;
  localparam int MINDT_W    = 20;
  localparam int CMD_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // fixed point constants
  localparam int Q12_ONE  = 4096;
  localparam int US_PER_S = 1000000;

  // shared multiplier and accumulator
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = ERR_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  // divider: |diff * 1e6| < 2^(ERR_W + 20), quotient kept to ERR_W-1 bits
  localparam int MAG_W     = ERR_W + 20;
  localparam int QW        = ERR_W - 1;
  localparam int HI_W      = MAG_W - QW;
  localparam int DIV_CNT_W = $clog2(QW);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BANK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DT_US   = 3'd4;

  // multiplier operand selects
  typedef enum logic [2:0] {
    A_USEC,
    A_KF,
    A_KF_INV,
    A_KP,
    A_KD
  } mul_a_sel_e;

  typedef enum logic [3:0] {
    B_DIFF_X,
    B_DIFF_Y,
    B_MEAS_X,
    B_OLD_X,
    B_MEAS_Y,
    B_OLD_Y,
    B_NEG_EX,
    B_EY,
    B_VX,
    B_VY
  } mul_b_sel_e;

  // controller to datapath
  typedef struct packed {
    logic       take_item;
    logic       store_prev;
    logic       mul_en;
    logic       mul_acc;
    mul_a_sel_e a_sel;
    mul_b_sel_e b_sel;
    logic       num_x_ld;
    logic       num_y_ld;
    logic       div_init;
    logic       div_step;
    logic       meas_ld;
    logic       vel_x_ld;
    logic       vel_y_ld;
    logic       bound_first;
    logic       pitch_ld;
    logic       emit;
  } pdag_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic cmd;
    logic have_prev;
    logic dt_gt_min;
    logic out_busy;
  } pdag_stat_t;

  // clamp to +-max_bank
  function automatic logic signed [CMD_W-1:0] bound_cmd(
    input logic signed [ACC_W-1:0] x,
    input logic        [BANK_W-1:0] mb
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [CMD_W-1:0] res;
    hi = signed'(ACC_W'(mb));
    if (x > hi) begin
      res = CMD_W'(hi);
    end else if (x < -hi) begin
      res = CMD_W'(-hi);
    end else begin
      res = CMD_W'(x);
    end
    return res;
  endfunction

  // saturate to the error width
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ERR_W-1:0] res;
    hi = signed'(ACC_W'({1'b0, {(ERR_W-1){1'b1}}}));
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      res = ERR_W'(hi);
    end else if (x < lo) begin
      res = ERR_W'(lo);
    end else begin
      res = ERR_W'(x);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/pdag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pdag_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire pdag_pkg::pdag_stat_t stat_i,
  output pdag_pkg::pdag_ctl_t       ctl_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CHK  = 5'd1;
  localparam logic [4:0] ST_MULX = 5'd2;
  localparam logic [4:0] ST_MULY = 5'd3;
  localparam logic [4:0] ST_NUMY = 5'd4;
  localparam logic [4:0] ST_DIVI = 5'd5;
  localparam logic [4:0] ST_DIV  = 5'd6;
  localparam logic [4:0] ST_MEAS = 5'd7;
  localparam logic [4:0] ST_FX1  = 5'd8;
  localparam logic [4:0] ST_FX2  = 5'd9;
  localparam logic [4:0] ST_FY1  = 5'd10;
  localparam logic [4:0] ST_FY2  = 5'd11;
  localparam logic [4:0] ST_FW   = 5'd12;
  localparam logic [4:0] ST_PM1  = 5'd13;
  localparam logic [4:0] ST_PM2  = 5'd14;
  localparam logic [4:0] ST_RM1  = 5'd15;
  localparam logic [4:0] ST_RM2  = 5'd16;
  localparam logic [4:0] ST_RFIN = 5'd17;

  logic [4:0]                     state_q, state_d;
  logic [pdag_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctl_o      = '0;
    ctl_o.a_sel = pdag_pkg::A_USEC;
    ctl_o.b_sel = pdag_pkg::B_DIFF_X;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.take_item = 1'b1;
          state_d         = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!stat_i.cmd && (!stat_i.have_prev || stat_i.dt_gt_min)) begin
          ctl_o.store_prev = 1'b1;
        end
        if (!stat_i.cmd && stat_i.have_prev && stat_i.dt_gt_min) begin
          state_d = ST_MULX;
        end else begin
          state_d = ST_PM1;
        end
      end
      ST_MULX: begin
        ctl_o.mul_en = 1'b1;
        ctl_o.a_sel  = pdag_pkg::A_USEC;
        ctl_o.b_sel  = pdag_pkg::B_DIFF_X;
        state_d      = ST_MULY;
      end
      ST_MULY: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.a_sel    = pdag_pkg::A_USEC;
        ctl_o.b_sel    = pdag_pkg::B_DIFF_Y;
        ctl_o.num_x_ld = 1'b1;
        state_d        = ST_NUMY;
      end
      ST_NUMY: begin
        ctl_o.num_y_ld = 1'b1;
        state_d        = ST_DIVI;
      end
      ST_DIVI: begin
        ctl_o.div_init = 1'b1;
        cnt_d          = pdag_pkg::DIV_CNT_W'(pdag_pkg::QW - 1);
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MEAS;
        end else begin
          cnt_d = cnt_q - pdag_pkg::DIV_CNT_W'(1);
        end
      end
      ST_MEAS: begin
        ctl_o.meas_ld = 1'b1;
        state_d       = ST_FX1;
      end
      ST_FX1: begin
        ctl_o.mul_en = 1'b1;
        ctl_o.a_sel  = pdag_pkg::A_KF;
        ctl_o.b_sel  = pdag_pkg::B_MEAS_X;
        state_d      = ST_FX2;
      end
      ST_FX2: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_acc = 1'b1;
        ctl_o.a_sel   = pdag_pkg::A_KF_INV;
        ctl_o.b_sel   = pdag_pkg::B_OLD_X;
        state_d       = ST_FY1;
      end
      ST_FY1: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.a_sel    = pdag_pkg::A_KF;
        ctl_o.b_sel    = pdag_pkg::B_MEAS_Y;
        ctl_o.vel_x_ld = 1'b1;
        state_d        = ST_FY2;
      end
      ST_FY2: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_acc = 1'b1;
        ctl_o.a_sel   = pdag_pkg::A_KF_INV;
        ctl_o.b_sel   = pdag_pkg::B_OLD_Y;
        state_d       = ST_FW;
      end
      ST_FW: begin
        ctl_o.vel_y_ld = 1'b1;
        state_d        = ST_PM1;
      end
      ST_PM1: begin
        ctl_o.mul_en = 1'b1;
        ctl_o.a_sel  = pdag_pkg::A_KP;
        ctl_o.b_sel  = pdag_pkg::B_NEG_EX;
        state_d      = ST_PM2;
      end
      ST_PM2: begin
        ctl_o.mul_en      = 1'b1;
        ctl_o.a_sel       = pdag_pkg::A_KD;
        ctl_o.b_sel       = pdag_pkg::B_VX;
        ctl_o.bound_first = 1'b1;
        state_d           = ST_RM1;
      end
      ST_RM1: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.a_sel    = pdag_pkg::A_KP;
        ctl_o.b_sel    = pdag_pkg::B_EY;
        ctl_o.pitch_ld = 1'b1;
        state_d        = ST_RM2;
      end
      ST_RM2: begin
        ctl_o.mul_en      = 1'b1;
        ctl_o.a_sel       = pdag_pkg::A_KD;
        ctl_o.b_sel       = pdag_pkg::B_VY;
        ctl_o.bound_first = 1'b1;
        state_d           = ST_RFIN;
      end
      ST_RFIN: begin
        if (!stat_i.out_busy) begin
          ctl_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/pdag_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pdag_dp (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // configuration
  input  wire                                       cfg_we_i,
  input  wire        [pdag_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire        [pdag_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request fields
  input  wire                                       command_i,
  input  wire        [pdag_pkg::TIME_W-1:0]         time_us_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]          err_x_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]          err_y_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]          ext_vel_x_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]          ext_vel_y_i,
  // result
  input  wire                                       out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [pdag_pkg::CMD_W-1:0]         pitch_cmd_o,
  output logic signed [pdag_pkg::CMD_W-1:0]         roll_cmd_o,
  output logic signed [pdag_pkg::ERR_W-1:0]         vel_used_x_o,
  output logic signed [pdag_pkg::ERR_W-1:0]         vel_used_y_o,
  // control
  input  wire pdag_pkg::pdag_ctl_t                  ctl_i,
  output pdag_pkg::pdag_stat_t                      stat_o
);

  localparam int EW = pdag_pkg::ERR_W;
  localparam int AW = pdag_pkg::ACC_W;
  localparam int TW = pdag_pkg::TIME_W;
  localparam int QW = pdag_pkg::QW;
  localparam int MW = pdag_pkg::MAG_W;
  localparam int HW = pdag_pkg::HI_W;

  localparam logic signed [AW-1:0] RND10 = AW'(512);
  localparam logic signed [AW-1:0] RND12 = AW'(2048);
  localparam logic signed [EW-1:0] MEAS_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] MEAS_MIN = {1'b1, {(EW-1){1'b0}}};

  // configuration registers
  logic [pdag_pkg::GAIN_W-1:0]  kp_q, kd_q;
  logic [pdag_pkg::KF_W-1:0]    kf_raw_q;
  logic [pdag_pkg::BANK_W-1:0]  bank_q;
  logic [pdag_pkg::MINDT_W-1:0] min_dt_q;

  // estimator state
  logic                  have_prev_q;
  logic [TW-1:0]         prev_time_q;
  logic signed [EW-1:0]  prev_ex_q, prev_ey_q;
  logic signed [EW-1:0]  vel_x_q, vel_y_q;

  // item registers
  logic                  cmd_q;
  logic [TW-1:0]         time_q, dt_q;
  logic signed [EW-1:0]  ex_q, ey_q, evx_q, evy_q;
  logic signed [EW:0]    diff_x_q, diff_y_q;

  // multiplier and accumulator
  logic signed [pdag_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pdag_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pdag_pkg::PROD_W-1:0]  prod;
  logic signed [AW-1:0]                acc_q, acc_d, acc_abs;
  logic signed [AW-1:0]                rr10, rr12;
  logic [pdag_pkg::KF_W-1:0]           kf, kf_inv;

  // divider lanes, x in lane 0 and y in lane 1
  logic [MW-1:0]        num_q   [2];
  logic                 neg_q   [2];
  logic                 sat_q   [2];
  logic [TW-1:0]        rem_q   [2];
  logic [TW-1:0]        rem_d   [2];
  logic [QW-1:0]        lo_q    [2];
  logic [QW-1:0]        lo_d    [2];
  logic                 sat_d   [2];
  logic signed [EW-1:0] meas_d  [2];
  logic signed [EW-1:0] meas_q  [2];
  logic [TW:0]          r2      [2];
  logic [HW-1:0]        hi      [2];

  // post processing
  logic signed [pdag_pkg::CMD_W-1:0] t_q, pitch_t_q;
  logic signed [EW-1:0]              vx_used, vy_used;
  logic                              out_valid_q;
  logic signed [pdag_pkg::CMD_W-1:0] pitch_out_q, roll_out_q;
  logic signed [EW-1:0]              velx_out_q, vely_out_q;

  assign kf     = (kf_raw_q > pdag_pkg::KF_W'(pdag_pkg::Q12_ONE)) ?
                  pdag_pkg::KF_W'(pdag_pkg::Q12_ONE) : kf_raw_q;
  assign kf_inv = pdag_pkg::KF_W'(pdag_pkg::Q12_ONE) - kf;

  assign vx_used = cmd_q ? evx_q : vel_x_q;
  assign vy_used = cmd_q ? evy_q : vel_y_q;

  always_comb begin
    case (ctl_i.a_sel)
      pdag_pkg::A_USEC:   mul_a = pdag_pkg::MUL_A_W'(pdag_pkg::US_PER_S);
      pdag_pkg::A_KF:     mul_a = signed'(pdag_pkg::MUL_A_W'(kf));
      pdag_pkg::A_KF_INV: mul_a = signed'(pdag_pkg::MUL_A_W'(kf_inv));
      pdag_pkg::A_KP:     mul_a = signed'(pdag_pkg::MUL_A_W'(kp_q));
      pdag_pkg::A_KD:     mul_a = signed'(pdag_pkg::MUL_A_W'(kd_q));
      default:            mul_a = '0;
    endcase
    case (ctl_i.b_sel)
      pdag_pkg::B_DIFF_X: mul_b = diff_x_q;
      pdag_pkg::B_DIFF_Y: mul_b = diff_y_q;
      pdag_pkg::B_MEAS_X: mul_b = pdag_pkg::MUL_B_W'(meas_q[0]);
      pdag_pkg::B_OLD_X:  mul_b = pdag_pkg::MUL_B_W'(vel_x_q);
      pdag_pkg::B_MEAS_Y: mul_b = pdag_pkg::MUL_B_W'(meas_q[1]);
      pdag_pkg::B_OLD_Y:  mul_b = pdag_pkg::MUL_B_W'(vel_y_q);
      pdag_pkg::B_NEG_EX: mul_b = -pdag_pkg::MUL_B_W'(ex_q);
      pdag_pkg::B_EY:     mul_b = pdag_pkg::MUL_B_W'(ey_q);
      pdag_pkg::B_VX:     mul_b = pdag_pkg::MUL_B_W'(vx_used);
      pdag_pkg::B_VY:     mul_b = pdag_pkg::MUL_B_W'(vy_used);
      default:            mul_b = '0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign acc_d = (ctl_i.mul_acc ? acc_q : '0) + AW'(prod);

  // round to nearest, ties up
  assign rr10    = (acc_q + RND10) >>> 10;
  assign rr12    = (acc_q + RND12) >>> 12;
  assign acc_abs = acc_q[AW-1] ? -acc_q : acc_q;

  // divider step and start
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi[l]    = num_q[l][MW-1:QW];
      r2[l]    = {rem_q[l], lo_q[l][QW-1]};
      rem_d[l] = rem_q[l];
      lo_d[l]  = lo_q[l];
      sat_d[l] = sat_q[l];
      if (ctl_i.div_init) begin
        sat_d[l] = TW'(hi[l]) >= dt_q;
        rem_d[l] = TW'(hi[l]);
        lo_d[l]  = num_q[l][QW-1:0];
      end else if (ctl_i.div_step) begin
        if (r2[l] >= {1'b0, dt_q}) begin
          rem_d[l] = TW'(r2[l] - {1'b0, dt_q});
          lo_d[l]  = {lo_q[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = r2[l][TW-1:0];
          lo_d[l]  = {lo_q[l][QW-2:0], 1'b0};
        end
      end
      if (neg_q[l]) begin
        meas_d[l] = sat_q[l] ? MEAS_MIN : -signed'({1'b0, lo_q[l]});
      end else begin
        meas_d[l] = sat_q[l] ? MEAS_MAX : signed'({1'b0, lo_q[l]});
      end
    end
  end

  // configuration and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= pdag_pkg::GAIN_W'(4096);
      kd_q        <= pdag_pkg::GAIN_W'(410);
      kf_raw_q    <= pdag_pkg::KF_W'(4096);
      bank_q      <= pdag_pkg::BANK_W'(737);
      min_dt_q    <= pdag_pkg::MINDT_W'(10000);
      have_prev_q <= 1'b0;
      prev_time_q <= '0;
      prev_ex_q   <= '0;
      prev_ey_q   <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pdag_pkg::CFG_KP_GAIN:     kp_q     <= cfg_data_i[pdag_pkg::GAIN_W-1:0];
          pdag_pkg::CFG_KD_GAIN:     kd_q     <= cfg_data_i[pdag_pkg::GAIN_W-1:0];
          pdag_pkg::CFG_FILTER_GAIN: kf_raw_q <= cfg_data_i[pdag_pkg::KF_W-1:0];
          pdag_pkg::CFG_MAX_BANK:    bank_q   <= cfg_data_i[pdag_pkg::BANK_W-1:0];
          pdag_pkg::CFG_MIN_DT_US:   min_dt_q <= cfg_data_i[pdag_pkg::MINDT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctl_i.store_prev) begin
        have_prev_q <= 1'b1;
        prev_time_q <= time_q;
        prev_ex_q   <= ex_q;
        prev_ey_q   <= ey_q;
      end
      if (ctl_i.vel_x_ld) begin
        vel_x_q <= pdag_pkg::sat_err(rr12);
      end
      if (ctl_i.vel_y_ld) begin
        vel_y_q <= pdag_pkg::sat_err(rr12);
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_item) begin
      cmd_q    <= command_i;
      time_q   <= time_us_i;
      dt_q     <= time_us_i - prev_time_q;
      ex_q     <= err_x_i;
      ey_q     <= err_y_i;
      evx_q    <= ext_vel_x_i;
      evy_q    <= ext_vel_y_i;
      diff_x_q <= (EW + 1)'(prev_ex_q) - (EW + 1)'(err_x_i);
      diff_y_q <= (EW + 1)'(prev_ey_q) - (EW + 1)'(err_y_i);
    end
    if (ctl_i.mul_en) begin
      acc_q <= acc_d;
    end
    if (ctl_i.num_x_ld) begin
      num_q[0] <= acc_abs[MW-1:0];
      neg_q[0] <= acc_q[AW-1];
    end
    if (ctl_i.num_y_ld) begin
      num_q[1] <= acc_abs[MW-1:0];
      neg_q[1] <= acc_q[AW-1];
    end
    for (int l = 0; l < 2; l++) begin
      rem_q[l] <= rem_d[l];
      lo_q[l]  <= lo_d[l];
      sat_q[l] <= sat_d[l];
      if (ctl_i.meas_ld) begin
        meas_q[l] <= meas_d[l];
      end
    end
    if (ctl_i.bound_first) begin
      t_q <= pdag_pkg::bound_cmd(rr10, bank_q);
    end
    if (ctl_i.pitch_ld) begin
      pitch_t_q <= pdag_pkg::bound_cmd(AW'(t_q) + rr10, bank_q);
    end
    if (ctl_i.emit) begin
      pitch_out_q <= pitch_t_q;
      roll_out_q  <= pdag_pkg::bound_cmd(AW'(t_q) - rr10, bank_q);
      velx_out_q  <= vx_used;
      vely_out_q  <= vy_used;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.have_prev = have_prev_q;
  assign stat_o.dt_gt_min = dt_q > TW'(min_dt_q);
  assign stat_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pitch_cmd_o  = pitch_out_q;
  assign roll_cmd_o   = roll_out_q;
  assign vel_used_x_o = velx_out_q;
  assign vel_used_y_o = vely_out_q;

endmodule

`default_nettype wire

// File: design/pd_attitude_guidance.sv
// a request whose velocity estimate is held or external goes from the check to the two
// bounded pd sums; an update first runs the numerator multiply, serial divide and filter
// (the bit-serial divide of the error change by elapsed time sets the long case); a new
// request is taken only once the previous result has reached the result register
// reset: async active low, gains return to defaults, estimator state cleared
`timescale 1ns / 1ps
`default_nettype none

module pd_attitude_guidance (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration write port
  input  wire                                   cfg_we_i,
  input  wire        [pdag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire        [pdag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   command_i,
  input  wire        [pdag_pkg::TIME_W-1:0]     time_us_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]      err_x_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]      err_y_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]      ext_vel_x_i,
  input  wire signed [pdag_pkg::ERR_W-1:0]      ext_vel_y_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [pdag_pkg::CMD_W-1:0]     pitch_cmd_o,
  output logic signed [pdag_pkg::CMD_W-1:0]     roll_cmd_o,
  output logic signed [pdag_pkg::ERR_W-1:0]     vel_used_x_o,
  output logic signed [pdag_pkg::ERR_W-1:0]     vel_used_y_o
);

  // sequencer commands and datapath flags
  pdag_pkg::pdag_ctl_t  ctl;
  pdag_pkg::pdag_stat_t stat;

  // controller: walks the request through check, numerator multiply,
  // serial divide, low-pass filter and the two bounded pd sums; holds the
  // final step while the previous result is still waiting in the output
  pdag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // datapath: config registers, estimator state, one shared multiply
  // accumulate unit, two divider lanes (x and y) and the result register
  // which lets a new request enter while a result is still pending
  pdag_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .time_us_i    (time_us_i),
    .err_x_i      (err_x_i),
    .err_y_i      (err_y_i),
    .ext_vel_x_i  (ext_vel_x_i),
    .ext_vel_y_i  (ext_vel_y_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pitch_cmd_o  (pitch_cmd_o),
    .roll_cmd_o   (roll_cmd_o),
    .vel_used_x_o (vel_used_x_o),
    .vel_used_y_o (vel_used_y_o),
    .ctl_i        (ctl),
    .stat_o       (stat)
  );

endmodule

`default_nettype wire

// File: test/tb_pd_attitude_guidance.sv
`timescale 1ns / 1ps

module tb_pd_attitude_guidance;
  import pdag_pkg::*;

  // request command codes
  localparam logic CMD_ESTIMATE = 1'b0;
  localparam logic CMD_EXTERNAL = 1'b1;

  // index that decodes to no register, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 60;    // longest latency plus margin
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int PROD_SHIFT      = 10;    // Q22 product down to Q12
  localparam int KF_SHIFT        = 12;    // Q12 filter weight
  localparam int PRINT_LIMIT     = 100;

  localparam longint ERR_MAX = (longint'(1) << (ERR_W - 1)) - 1;
  localparam longint ERR_MIN = -ERR_MAX - 1;

  typedef struct packed {
    logic                    command;
    logic [TIME_W-1:0]       time_us;
    logic signed [ERR_W-1:0] err_x;
    logic signed [ERR_W-1:0] err_y;
    logic signed [ERR_W-1:0] ext_vel_x;
    logic signed [ERR_W-1:0] ext_vel_y;
  } guidance_req_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] roll;
    logic signed [ERR_W-1:0] vel_x;
    logic signed [ERR_W-1:0] vel_y;
  } attitude_cmd_t;

  // dut pins, all driven from time zero
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    command_i   = 1'b0;
  logic [TIME_W-1:0]       time_us_i   = '0;
  logic signed [ERR_W-1:0] err_x_i     = '0;
  logic signed [ERR_W-1:0] err_y_i     = '0;
  logic signed [ERR_W-1:0] ext_vel_x_i = '0;
  logic signed [ERR_W-1:0] ext_vel_y_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [CMD_W-1:0] pitch_cmd_o;
  logic signed [CMD_W-1:0] roll_cmd_o;
  logic signed [ERR_W-1:0] vel_used_x_o;
  logic signed [ERR_W-1:0] vel_used_y_o;

  // mirror of the register file, reset values
  logic [GAIN_W-1:0]  gain_kp      = 16'd4096;
  logic [GAIN_W-1:0]  gain_kd      = 16'd410;
  logic [KF_W-1:0]    weight_kf    = 13'd4096;
  logic [BANK_W-1:0]  bank_limit   = 13'd737;
  logic [MINDT_W-1:0] min_interval = 20'd10000;

  // mirror of the velocity estimator
  logic              have_prev_s = 1'b0;
  logic [TIME_W-1:0] prev_time_s = '0;
  longint            prev_ex_s   = 0;
  longint            prev_ey_s   = 0;
  longint            vel_x_s     = 0;
  longint            vel_y_s     = 0;

  attitude_cmd_t attitude_due_q[$];  // commands owed by the dut, oldest first
  int            err_count    = 0;
  int            quiet_cycles = 0;
  int unsigned   ready_hold   = 0;
  bit            idle_en      = 1'b1;  // random gaps and stalls on both sides

  pd_attitude_guidance DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .time_us_i    (time_us_i),
    .err_x_i      (err_x_i),
    .err_y_i      (err_y_i),
    .ext_vel_x_i  (ext_vel_x_i),
    .ext_vel_y_i  (ext_vel_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pitch_cmd_o  (pitch_cmd_o),
    .roll_cmd_o   (roll_cmd_o),
    .vel_used_x_o (vel_used_x_o),
    .vel_used_y_o (vel_used_y_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // divide by 2^s, round to nearest with ties toward +inf
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // one axis of the velocity estimator: measured rate blended into the old estimate
  function automatic longint filtered_velocity(input longint prev_err, input longint cur_err,
                                               input longint old_vel, input longint dt);
    longint meas;
    longint kf;
    meas = clamp(((prev_err - cur_err) * US_PER_S) / dt, ERR_MIN, ERR_MAX);
    // weights above one saturate at one
    kf = (weight_kf > Q12_ONE) ? Q12_ONE : weight_kf;
    return clamp(round_shift(kf * meas + (Q12_ONE - kf) * old_vel, KF_SHIFT),
                 ERR_MIN, ERR_MAX);
  endfunction

  // full guidance law for one request, advances the estimator mirror
  function automatic attitude_cmd_t guidance_law(input guidance_req_t r);
    attitude_cmd_t     res;
    logic [TIME_W-1:0] dt;
    longint            ex;
    longint            ey;
    longint            vx;
    longint            vy;
    longint            kp;
    longint            kd;
    longint            bank;
    longint            pitch;
    longint            roll;
    ex   = signed'(r.err_x);
    ey   = signed'(r.err_y);
    kp   = gain_kp;
    kd   = gain_kd;
    bank = bank_limit;
    if (r.command == CMD_EXTERNAL) begin
      vx = signed'(r.ext_vel_x);
      vy = signed'(r.ext_vel_y);
    end else begin
      if (!have_prev_s) begin
        // first sample only seeds the history
        have_prev_s = 1'b1;
        prev_time_s = r.time_us;
        prev_ex_s   = ex;
        prev_ey_s   = ey;
      end else begin
        // elapsed time wraps, a backwards timestamp looks like a long interval
        dt = r.time_us - prev_time_s;
        if (dt > TIME_W'(min_interval)) begin
          vel_x_s     = filtered_velocity(prev_ex_s, ex, vel_x_s, longint'({32'd0, dt}));
          vel_y_s     = filtered_velocity(prev_ey_s, ey, vel_y_s, longint'({32'd0, dt}));
          prev_time_s = r.time_us;
          prev_ex_s   = ex;
          prev_ey_s   = ey;
        end
      end
      vx = vel_x_s;
      vy = vel_y_s;
    end
    pitch = clamp(round_shift(-kp * ex, PROD_SHIFT), -bank, bank);
    pitch = clamp(pitch + round_shift(kd * vx, PROD_SHIFT), -bank, bank);
    roll  = clamp(round_shift(kp * ey, PROD_SHIFT), -bank, bank);
    roll  = clamp(roll - round_shift(kd * vy, PROD_SHIFT), -bank, bank);
    res.pitch = pitch[CMD_W-1:0];
    res.roll  = roll[CMD_W-1:0];
    res.vel_x = vx[ERR_W-1:0];
    res.vel_y = vy[ERR_W-1:0];
    return res;
  endfunction

  function automatic guidance_req_t make_req(input logic cmd, input logic [TIME_W-1:0] t,
                                             input longint ex, input longint ey,
                                             input longint vx, input longint vy);
    guidance_req_t r;
    r.command   = cmd;
    r.time_us   = t;
    r.err_x     = ex[ERR_W-1:0];
    r.err_y     = ey[ERR_W-1:0];
    r.ext_vel_x = vx[ERR_W-1:0];
    r.ext_vel_y = vy[ERR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // one request: optional gap, hold valid until accepted, predict on acceptance
  task automatic send_request(input guidance_req_t r);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    command_i   = r.command;
    time_us_i   = r.time_us;
    err_x_i     = r.err_x;
    err_y_i     = r.err_y;
    ext_vel_x_i = r.ext_vel_x;
    ext_vel_y_i = r.ext_vel_y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    attitude_due_q.push_back(guidance_law(r));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // every result back, ends on a falling edge
  task automatic wait_drained();
    while (attitude_due_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_KP_GAIN:     gain_kp      = value[GAIN_W-1:0];
      CFG_KD_GAIN:     gain_kd      = value[GAIN_W-1:0];
      CFG_FILTER_GAIN: weight_kf    = value[KF_W-1:0];
      CFG_MAX_BANK:    bank_limit   = value[BANK_W-1:0];
      CFG_MIN_DT_US:   min_interval = value[MINDT_W-1:0];
      default: ;
    endcase
  endtask

  // all five registers, only once the block has gone quiet
  task automatic load_registers(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                                input logic [KF_W-1:0] kf, input logic [BANK_W-1:0] bank,
                                input logic [MINDT_W-1:0] min_dt);
    wait_drained();
    write_reg(CFG_KP_GAIN, CFG_DATA_W'(kp));
    write_reg(CFG_KD_GAIN, CFG_DATA_W'(kd));
    write_reg(CFG_FILTER_GAIN, CFG_DATA_W'(kf));
    write_reg(CFG_MAX_BANK, CFG_DATA_W'(bank));
    write_reg(CFG_MIN_DT_US, CFG_DATA_W'(min_dt));
  endtask

  // reset registers: seeding, short and exact intervals, wrap, external extremes
  task automatic test_estimator_cases();
    send_request(make_req(CMD_ESTIMATE, 32'd1000, 100, -200, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'd6000, 300, -100, 0, 0));
    // interval equal to the minimum does not update
    send_request(make_req(CMD_ESTIMATE, 32'd11000, 400, 0, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'd11001, -5000, 7000, 0, 0));
    send_request(make_req(CMD_EXTERNAL, 32'd11002, ERR_MAX, ERR_MIN, ERR_MAX, ERR_MIN));
    send_request(make_req(CMD_EXTERNAL, 32'd11003, ERR_MIN, ERR_MAX, ERR_MIN, ERR_MAX));
    // timestamp runs backwards
    send_request(make_req(CMD_ESTIMATE, 32'd500, ERR_MAX, ERR_MIN, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'hFFFF_FFFF, ERR_MIN, ERR_MAX, 0, 0));
    // counter wraps forward past zero
    send_request(make_req(CMD_ESTIMATE, 32'h0000_4000, 0, 0, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'h0001_0000, 0, 0, 0, 0));
    send_request(make_req(CMD_EXTERNAL, $urandom(), signed'(ERR_W'($urandom())),
                          signed'(ERR_W'($urandom())), signed'(ERR_W'($urandom())),
                          signed'(ERR_W'($urandom()))));
  endtask

  // full gains, weight and bank beyond range, zero minimum interval
  task automatic test_register_extremes();
    load_registers('1, '1, '1, '1, '0);
    // one microsecond swing saturates the measured rate
    send_request(make_req(CMD_ESTIMATE, 32'h0001_0001, ERR_MIN, ERR_MAX, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'h0001_0001, 0, 0, 0, 0));
    send_request(make_req(CMD_ESTIMATE, 32'h0001_0002, ERR_MAX, ERR_MIN, 0, 0));
    send_request(make_req(CMD_EXTERNAL, 32'h0001_0002, ERR_MAX, ERR_MAX, ERR_MIN, ERR_MIN));
    // weight exactly one, bank at the top of its range
    load_registers(16'd4096, 16'd410, 13'd4096, 13'd6434, '0);
    send_request(make_req(CMD_ESTIMATE, 32'h0001_0003, 1000, -1000, 0, 0));
    send_request(make_req(CMD_EXTERNAL, 32'h0001_0003, ERR_MIN, ERR_MIN, ERR_MAX, ERR_MAX));
  endtask

  // zero gains, weight and bank, longest minimum interval
  task automatic test_register_zero();
    load_registers('0, '0, '0, '0, '1);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    send_request(make_req(CMD_ESTIMATE, 32'h0011_0001, 12345, -54321, 0, 0));
    // zero weight keeps the old estimate even on an update
    send_request(make_req(CMD_ESTIMATE, 32'h0011_0003, -777, 888, 0, 0));
    send_request(make_req(CMD_EXTERNAL, 32'h0011_0004, ERR_MAX, ERR_MIN, 4321, -4321));
  endtask

  // random registers per phase, then a tracked target with some noise
  task automatic test_random_tracking();
    guidance_req_t      r;
    logic [TIME_W-1:0]  clock_us;
    longint             walk_x;
    longint             walk_y;
    int unsigned        span;
    int unsigned        min_dt;
    int unsigned        kind;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  kd;
    logic [KF_W-1:0]    kf;
    logic [BANK_W-1:0]  bank;
    clock_us = 32'h0020_0000;
    walk_x   = 0;
    walk_y   = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: kp = '0;
        1: kp = '1;
        default: kp = GAIN_W'($urandom_range(0, 12000));
      endcase
      case ($urandom_range(0, 7))
        0: kd = '0;
        1: kd = '1;
        default: kd = GAIN_W'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 5))
        0: kf = '0;
        1: kf = KF_W'($urandom_range(4097, 8191));
        2: kf = 13'd4096;
        default: kf = KF_W'($urandom_range(1, 4095));
      endcase
      case ($urandom_range(0, 5))
        0: bank = '0;
        1: bank = BANK_W'($urandom_range(6435, 8191));
        2: bank = 13'd6434;
        default: bank = BANK_W'($urandom_range(1, 6433));
      endcase
      case ($urandom_range(0, 7))
        0: min_dt = 0;
        1: min_dt = 20'hFFFFF;
        2: min_dt = 1000000;
        default: min_dt = $urandom_range(1, 50000);
      endcase
      load_registers(kp, kd, kf, bank, MINDT_W'(min_dt));
      // some phases run without gaps, the last one always does
      idle_en = (phase != RANDOM_PHASES - 1) && (phase % 3 != 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
          0: clock_us += $urandom_range(0, min_dt);
          1: clock_us += min_dt + $urandom_range(1, 2000);
          2: clock_us += min_dt + $urandom_range(1, 300000);
          default: clock_us += min_dt + 1;
        endcase
        // occasional step back in time
        if (kind == 18) begin
          clock_us -= $urandom_range(1, 5000) + min_dt;
        end
        case ($urandom_range(0, 3))
          0: span = 64;
          1: span = 4096;
          2: span = 1 << 18;
          default: span = 1 << 23;
        endcase
        walk_x = clamp(walk_x + longint'($urandom_range(0, 2 * span)) - longint'(span),
                       ERR_MIN, ERR_MAX);
        walk_y = clamp(walk_y + longint'($urandom_range(0, 2 * span)) - longint'(span),
                       ERR_MIN, ERR_MAX);
        r.command = (kind < 5) ? CMD_EXTERNAL : CMD_ESTIMATE;
        r.time_us = clock_us;
        r.err_x   = walk_x[ERR_W-1:0];
        r.err_y   = walk_y[ERR_W-1:0];
        if (kind < 2) begin
          r.ext_vel_x = ERR_W'($urandom());
          r.ext_vel_y = ERR_W'($urandom());
        end else begin
          r.ext_vel_x = ERR_W'(longint'($urandom_range(0, 2 * span)) - longint'(span));
          r.ext_vel_y = ERR_W'(longint'($urandom_range(0, 2 * span)) - longint'(span));
        end
        // noise: timestamp and errors unrelated to the track
        if (kind == 19) begin
          r.time_us = $urandom();
          r.err_x   = ERR_W'($urandom());
          r.err_y   = ERR_W'($urandom());
        end
        send_request(r);
      end
    end
  endtask

  // result side backpressure in bursts
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready_i = 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      ready_hold  = $urandom_range(0, 6);
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // compare each accepted result against the oldest owed command
  always @(posedge clk_i) begin : check_results
    attitude_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (attitude_due_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = attitude_due_q.pop_front();
        check_field("pitch_cmd", signed'(pitch_cmd_o), signed'(want.pitch));
        check_field("roll_cmd", signed'(roll_cmd_o), signed'(want.roll));
        check_field("vel_used_x", signed'(vel_used_x_o), signed'(want.vel_x));
        check_field("vel_used_y", signed'(vel_used_y_o), signed'(want.vel_y));
      end
    end
  end

  // hang detection: no handshake on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_estimator_cases();
    test_register_extremes();
    test_register_zero();
    test_random_tracking();
    wait_drained();
    // catch any stray result after the last one owed
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
